/* rtl/core/omni4_pkg.sv */
// ----------------------------------------------------------------------------
// omni4_pkg
// Shared types and constants of the four-wheel omni drive mixer: CORDIC
// cell payload, arctangent table and fixed-point limits.
// ----------------------------------------------------------------------------
package omni4_pkg;

  localparam int WHEEL_COUNT  = 4;
  localparam int CORDIC_STEPS = 20;
  localparam int LEVEL_W      = 9;
  localparam int HEADING_W    = 16;
  localparam int DUTY_W       = 8;
  localparam int XY_W         = 32;
  localparam int Z_W          = 34;
  localparam int TRIG_W       = 16;
  localparam int PROD_W       = LEVEL_W + TRIG_W;
  localparam int WVAL_W       = 10;

  // gain-corrected 1.0 at scale 2^30
  localparam logic signed [XY_W-1:0]   CORDIC_X0 = 32'sd652032874;
  localparam logic signed [TRIG_W-1:0] TRIG_MAX  = 16'sd32767;

  // one rotation step travelling down the cell chain
  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
    logic signed [LEVEL_W-1:0] level;
    logic [1:0]                quad;
  } omni4_cordic_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [Z_W-1:0] atan_units(input int step);
    logic signed [Z_W-1:0] a;
    case (step)
      0:       a = 34'sd536870912;
      1:       a = 34'sd316933406;
      2:       a = 34'sd167458907;
      3:       a = 34'sd85004756;
      4:       a = 34'sd42667331;
      5:       a = 34'sd21354465;
      6:       a = 34'sd10679838;
      7:       a = 34'sd5340245;
      8:       a = 34'sd2670163;
      9:       a = 34'sd1335087;
      10:      a = 34'sd667544;
      11:      a = 34'sd333772;
      12:      a = 34'sd166886;
      13:      a = 34'sd83443;
      14:      a = 34'sd41722;
      15:      a = 34'sd20861;
      16:      a = 34'sd10430;
      17:      a = 34'sd5215;
      18:      a = 34'sd2608;
      19:      a = 34'sd1304;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/core/omni4_if.sv */
// ----------------------------------------------------------------------------
// omni4 channel interfaces
// Valid/ready channels for drive requests and wheel commands.
// ----------------------------------------------------------------------------
interface omni4_in_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] drive_level;
  logic [15:0]       heading;

  modport source (output valid, output drive_level, output heading, input ready);
  modport sink   (input valid, input drive_level, input heading, output ready);
endinterface

interface omni4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_wheel0;
  logic [7:0] duty_wheel1;
  logic [7:0] duty_wheel2;
  logic [7:0] duty_wheel3;
  logic       dir_wheel0;
  logic       dir_wheel1;
  logic       dir_wheel2;
  logic       dir_wheel3;

  modport source (output valid, input ready,
                  output duty_wheel0, output duty_wheel1,
                  output duty_wheel2, output duty_wheel3,
                  output dir_wheel0, output dir_wheel1,
                  output dir_wheel2, output dir_wheel3);
  modport sink   (input valid, output ready,
                  input duty_wheel0, input duty_wheel1,
                  input duty_wheel2, input duty_wheel3,
                  input dir_wheel0, input dir_wheel1,
                  input dir_wheel2, input dir_wheel3);
endinterface

/* rtl/core/omni_four_wheel_drive_mixer.sv */
// ----------------------------------------------------------------------------
// omni_four_wheel_drive_mixer
// Four-wheel omni drive inverse kinematics: CORDIC sine/cosine chain,
// drive level scaling and per-wheel duty/direction with reverse mask.
// ----------------------------------------------------------------------------
// Pipeline: 20 CORDIC cells, then the fold, multiply and output stages.
// Throughput: one request per cycle; the whole chain advances together and
//   holds only while a result is waiting on the output.
// Reset: synchronous active-low rst_n clears all valid bits and reverse_mask.
module omni_four_wheel_drive_mixer (
  input  logic        clk,
  input  logic        rst_n,
  omni4_in_if.sink    in_chan,
  omni4_out_if.source out_chan,
  input  logic        cfg_we,
  input  logic [omni4_pkg::WHEEL_COUNT-1:0] cfg_wdata
);
  import omni4_pkg::*;

  logic                   en;
  logic [WHEEL_COUNT-1:0] reverse_mask_r;
  logic [CORDIC_STEPS:0]  chain_valid;
  omni4_cordic_t          chain_data [CORDIC_STEPS+1];
  logic                   out_valid;
  logic [WHEEL_COUNT-1:0][DUTY_W-1:0] duty;
  logic [WHEEL_COUNT-1:0] dir;

  // chain advances unless a result is stalled at the output
  assign en            = !out_valid || out_chan.ready;
  assign in_chan.ready = en;

  // reverse mask register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_mask_r <= '0;
    end else if (cfg_we) begin
      reverse_mask_r <= cfg_wdata;
    end
  end

  // chain head: start vector and residue angle
  always_comb begin
    chain_valid[0]      = in_chan.valid;
    chain_data[0].x     = CORDIC_X0;
    chain_data[0].y     = '0;
    chain_data[0].z     = {2'b00, in_chan.heading[13:0], 18'b0};
    chain_data[0].level = in_chan.drive_level;
    chain_data[0].quad  = in_chan.heading[15:14];
  end

  // CORDIC cell chain
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    omni4_cordic_cell #(.STEP(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (chain_valid[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  omni4_wheel_stage u_wheel (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (chain_valid[CORDIC_STEPS]),
    .in_data      (chain_data[CORDIC_STEPS]),
    .reverse_mask (reverse_mask_r),
    .out_valid    (out_valid),
    .duty         (duty),
    .dir          (dir)
  );

  assign out_chan.valid       = out_valid;
  assign out_chan.duty_wheel0 = duty[0];
  assign out_chan.duty_wheel1 = duty[1];
  assign out_chan.duty_wheel2 = duty[2];
  assign out_chan.duty_wheel3 = duty[3];
  assign out_chan.dir_wheel0  = dir[0];
  assign out_chan.dir_wheel1  = dir[1];
  assign out_chan.dir_wheel2  = dir[2];
  assign out_chan.dir_wheel3  = dir[3];

endmodule

/* rtl/core/omni4_cordic_cell.sv */
// ----------------------------------------------------------------------------
// omni4_cordic_cell
// One rotation-mode CORDIC step with its pipeline register.
// ----------------------------------------------------------------------------
module omni4_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  omni4_pkg::omni4_cordic_t in_data,
  output logic                    out_valid,
  output omni4_pkg::omni4_cordic_t out_data
);
  import omni4_pkg::*;

  logic signed [XY_W-1:0] x_in;
  logic signed [XY_W-1:0] y_in;
  logic signed [Z_W-1:0]  z_in;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic                   valid_r;
  omni4_cordic_t          data_r;
  omni4_cordic_t          data_nxt;

  // rotate toward zero residual angle; >>> floors negative values
  always_comb begin
    x_in     = in_data.x;
    y_in     = in_data.y;
    z_in     = in_data.z;
    dx       = y_in >>> STEP;
    dy       = x_in >>> STEP;
    data_nxt = in_data;
    if (!z_in[Z_W-1]) begin
      data_nxt.x = x_in - dx;
      data_nxt.y = y_in + dy;
      data_nxt.z = z_in - atan_units(STEP);
    end else begin
      data_nxt.x = x_in + dx;
      data_nxt.y = y_in - dy;
      data_nxt.z = z_in + atan_units(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* rtl/core/omni4_wheel_stage.sv */
// ----------------------------------------------------------------------------
// omni4_wheel_stage
// Rounds and folds sine/cosine, scales by drive level and forms the four
// wheel duties and direction bits over three register stages.
// ----------------------------------------------------------------------------
module omni4_wheel_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  omni4_pkg::omni4_cordic_t    in_data,
  input  logic [omni4_pkg::WHEEL_COUNT-1:0] reverse_mask,
  output logic                        out_valid,
  output logic [omni4_pkg::WHEEL_COUNT-1:0][omni4_pkg::DUTY_W-1:0] duty,
  output logic [omni4_pkg::WHEEL_COUNT-1:0] dir
);
  import omni4_pkg::*;

  // 1.15 rounding with symmetric saturation
  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0]   sum;
    logic signed [XY_W:0]   t;
    logic signed [TRIG_W-1:0] r;
    sum = {v[XY_W-1], v} + 33'sd16384;
    t   = sum >>> 15;
    if (t > 33'sd32767) begin
      r = TRIG_MAX;
    end else if (t < -33'sd32767) begin
      r = -TRIG_MAX;
    end else begin
      r = t[TRIG_W-1:0];
    end
    return r;
  endfunction

  // product / 2^15 truncated toward zero
  function automatic logic signed [WVAL_W-1:0] trunc15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] sum;
    sum = p + (p[PROD_W-1] ? 25'sd32767 : 25'sd0);
    return sum[PROD_W-1:15];
  endfunction

  function automatic logic [DUTY_W-1:0] mag8(input logic signed [WVAL_W-1:0] v);
    logic signed [WVAL_W-1:0] a;
    a = v[WVAL_W-1] ? -v : v;
    return a[DUTY_W-1:0];
  endfunction

  logic signed [TRIG_W-1:0]  s_q;
  logic signed [TRIG_W-1:0]  c_q;
  logic signed [TRIG_W-1:0]  sin_nxt;
  logic signed [TRIG_W-1:0]  cos_nxt;
  logic signed [TRIG_W-1:0]  sin_r;
  logic signed [TRIG_W-1:0]  cos_r;
  logic signed [LEVEL_W-1:0] level_r;
  logic signed [PROD_W-1:0]  psin_r;
  logic signed [PROD_W-1:0]  pcos_r;
  logic signed [WVAL_W-1:0]  ts;
  logic signed [WVAL_W-1:0]  tc;
  logic [WHEEL_COUNT-1:0][DUTY_W-1:0] duty_nxt;
  logic [WHEEL_COUNT-1:0]    dir_nxt;
  logic [WHEEL_COUNT-1:0][DUTY_W-1:0] duty_r;
  logic [WHEEL_COUNT-1:0]    dir_r;
  logic [2:0]                valid_r;

  // quadrant folding
  always_comb begin
    s_q = to_q15(in_data.y);
    c_q = to_q15(in_data.x);
    case (in_data.quad)
      2'd0:    begin sin_nxt = s_q;  cos_nxt = c_q;  end
      2'd1:    begin sin_nxt = c_q;  cos_nxt = -s_q; end
      2'd2:    begin sin_nxt = -s_q; cos_nxt = -c_q; end
      default: begin sin_nxt = -c_q; cos_nxt = s_q;  end
    endcase
  end

  // wheel values: P*sin, -P*cos, -P*sin, P*cos
  always_comb begin
    ts          = trunc15(psin_r);
    tc          = trunc15(pcos_r);
    duty_nxt[0] = mag8(ts);
    duty_nxt[1] = mag8(tc);
    duty_nxt[2] = mag8(ts);
    duty_nxt[3] = mag8(tc);
    dir_nxt[0]  = !ts[WVAL_W-1];
    dir_nxt[1]  = tc[WVAL_W-1] || (tc == '0);
    dir_nxt[2]  = ts[WVAL_W-1] || (ts == '0);
    dir_nxt[3]  = !tc[WVAL_W-1];
    dir_nxt     = dir_nxt ^ reverse_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[1:0], in_valid};
    end
  end

  // fold, multiply, output registers
  always_ff @(posedge clk) begin
    if (en) begin
      sin_r   <= sin_nxt;
      cos_r   <= cos_nxt;
      level_r <= in_data.level;
      psin_r  <= PROD_W'(level_r * sin_r);
      pcos_r  <= PROD_W'(level_r * cos_r);
      duty_r  <= duty_nxt;
      dir_r   <= dir_nxt;
    end
  end

  assign out_valid = valid_r[2];
  assign duty      = duty_r;
  assign dir       = dir_r;

endmodule
